FILE: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the checker module.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");

// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

FILE: sv/porm_pkg.sv
// ----------------------------------------------------------------------------
// porm_pkg
// Types, constants and helper functions for the point transform.
// ----------------------------------------------------------------------------
`default_nettype none

package porm_pkg;

	localparam int ROTATE_STEPS_DEF = 16;

	localparam logic signed [31:0] CORDIC_GAIN = 32'sd652032874;
	localparam logic signed [31:0] ONE_Q30     = 32'sd1073741824;
	localparam logic [31:0]        SCALE_RESET = 32'd65536;

	localparam logic signed [65:0] ROUND_Q30 = 66'sd536870912;
	localparam logic signed [65:0] ROUND_Q16 = 66'sd32768;
	localparam logic signed [65:0] S32_MAX   = 66'sd2147483647;
	localparam logic signed [65:0] S32_MIN   = -66'sd2147483648;

	localparam logic [2:0] CFG_OFFSET_X      = 3'd0;
	localparam logic [2:0] CFG_OFFSET_Y      = 3'd1;
	localparam logic [2:0] CFG_TURN_ANGLE    = 3'd2;
	localparam logic [2:0] CFG_MIRROR_ENABLE = 3'd3;
	localparam logic [2:0] CFG_SCALE_FACTOR  = 3'd4;

	typedef struct packed {
		logic signed [31:0] point_x;
		logic signed [31:0] point_y;
	} point_t;

	typedef struct packed {
		logic signed [31:0] result_x;
		logic signed [31:0] result_y;
		logic               overflow;
	} result_t;

	typedef struct packed {
		logic               busy;
		logic signed [31:0] cos_v;
		logic signed [31:0] sin_v;
	} trig_t;

	function automatic logic [29:0] atan_turn(input logic [4:0] idx);
		logic [29:0] a;
		case (idx)
			5'd0:    a = 30'd536870912;
			5'd1:    a = 30'd316933406;
			5'd2:    a = 30'd167458907;
			5'd3:    a = 30'd85004756;
			5'd4:    a = 30'd42667331;
			5'd5:    a = 30'd21354465;
			5'd6:    a = 30'd10679838;
			5'd7:    a = 30'd5340245;
			5'd8:    a = 30'd2670163;
			5'd9:    a = 30'd1335087;
			5'd10:   a = 30'd667544;
			5'd11:   a = 30'd333772;
			5'd12:   a = 30'd166886;
			5'd13:   a = 30'd83443;
			5'd14:   a = 30'd41722;
			5'd15:   a = 30'd20861;
			5'd16:   a = 30'd10430;
			5'd17:   a = 30'd5215;
			5'd18:   a = 30'd2608;
			5'd19:   a = 30'd1304;
			5'd20:   a = 30'd652;
			5'd21:   a = 30'd326;
			5'd22:   a = 30'd163;
			5'd23:   a = 30'd81;
			default: a = 30'd0;
		endcase
		return a;
	endfunction

	function automatic logic signed [31:0] sat_val(input logic signed [65:0] v);
		logic signed [31:0] r;
		if (v > S32_MAX) begin
			r = 32'sh7fffffff;
		end else if (v < S32_MIN) begin
			r = 32'sh80000000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

	function automatic logic sat_hit(input logic signed [65:0] v);
		return (v > S32_MAX) || (v < S32_MIN);
	endfunction

endpackage

`default_nettype wire

FILE: sv/porm_sincos.sv
// ----------------------------------------------------------------------------
// porm_sincos
// Iterative CORDIC: recomputes cosine and sine of the turn angle, one
// micro-rotation per cycle, after each angle write.
// ----------------------------------------------------------------------------
`default_nettype none

module porm_sincos #(
	parameter int ROTATE_STEPS = porm_pkg::ROTATE_STEPS_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic [15:0]   angle,
	output porm_pkg::trig_t    trig
);

	localparam int STEP_W = (ROTATE_STEPS > 1) ? $clog2(ROTATE_STEPS) : 1;
	localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(ROTATE_STEPS - 1);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_LOAD = 2'd1;
	localparam logic [1:0] ST_RUN  = 2'd2;
	localparam logic [1:0] ST_FIN  = 2'd3;

	logic [1:0]         state_q;
	logic [STEP_W-1:0]  cnt_q;
	logic signed [32:0] x_q;
	logic signed [32:0] y_q;
	logic signed [33:0] z_q;
	logic [1:0]         quad_q;
	logic               exact_q;
	logic signed [31:0] cos_q;
	logic signed [31:0] sin_q;

	logic [16:0]        ang_sum;
	logic [1:0]         quad;
	logic [15:0]        resid;
	logic signed [32:0] dx;
	logic signed [32:0] dy;
	logic signed [33:0] at;
	logic signed [33:0] c_raw;
	logic signed [33:0] s_raw;
	logic signed [33:0] c_rot;
	logic signed [33:0] s_rot;

	function automatic logic signed [31:0] clamp_unit(input logic signed [33:0] v);
		logic signed [31:0] r;
		if (v > 34'(porm_pkg::ONE_Q30)) begin
			r = porm_pkg::ONE_Q30;
		end else if (v < -34'(porm_pkg::ONE_Q30)) begin
			r = -porm_pkg::ONE_Q30;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

	always_comb begin
		ang_sum = {1'b0, angle} + 17'd8192;
		quad    = ang_sum[15:14];
		resid   = angle - {quad, 14'd0};
		dx      = y_q >>> cnt_q;
		dy      = x_q >>> cnt_q;
		at      = $signed({4'd0, porm_pkg::atan_turn(5'(cnt_q))});
		c_raw   = exact_q ? 34'(porm_pkg::ONE_Q30) : 34'(x_q);
		s_raw   = exact_q ? 34'sd0 : 34'(y_q);
		case (quad_q)
			2'd1: begin
				c_rot = -s_raw;
				s_rot = c_raw;
			end
			2'd2: begin
				c_rot = -c_raw;
				s_rot = -s_raw;
			end
			2'd3: begin
				c_rot = s_raw;
				s_rot = -c_raw;
			end
			default: begin
				c_rot = c_raw;
				s_rot = s_raw;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			cos_q   <= porm_pkg::ONE_Q30;
			sin_q   <= '0;
		end else if (start) begin
			state_q <= ST_LOAD;
		end else begin
			case (state_q)
				ST_LOAD: begin
					state_q <= ST_RUN;
					cnt_q   <= '0;
				end
				ST_RUN: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == LAST_STEP) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					cos_q   <= clamp_unit(c_rot);
					sin_q   <= clamp_unit(s_rot);
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_LOAD) begin
			x_q     <= 33'(porm_pkg::CORDIC_GAIN);
			y_q     <= '0;
			z_q     <= 34'($signed({resid, 16'd0}));
			quad_q  <= quad;
			exact_q <= (resid == 16'd0);
		end else if (state_q == ST_RUN) begin
			if (!z_q[33]) begin
				x_q <= x_q - dx;
				y_q <= y_q + dy;
				z_q <= z_q - at;
			end else begin
				x_q <= x_q + dx;
				y_q <= y_q - dy;
				z_q <= z_q + at;
			end
		end
	end

	assign trig.busy  = (state_q != ST_IDLE);
	assign trig.cos_v = cos_q;
	assign trig.sin_v = sin_q;

endmodule

`default_nettype wire

FILE: sv/porm_datapath.sv
// ----------------------------------------------------------------------------
// porm_datapath
// Five-stage point pipeline: offset, products, rotate and mirror,
// scale product, round and saturate.
// ----------------------------------------------------------------------------
`default_nettype none

module porm_datapath (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire porm_pkg::point_t    in_data,
	output logic                     out_valid,
	input  wire logic                out_stall,
	output porm_pkg::result_t        out_data,
	input  wire logic signed [31:0]  offset_x,
	input  wire logic signed [31:0]  offset_y,
	input  wire logic                mirror,
	input  wire logic [31:0]         scale,
	input  wire porm_pkg::trig_t     trig
);

	logic advance;
	logic take;

	logic v_s1, v_s2, v_s3, v_s4, v_s5;

	logic signed [31:0] x_s1, y_s1;
	logic               ov_s1;
	logic signed [63:0] cx_s2, sy_s2, sx_s2, cy_s2;
	logic               ov_s2;
	logic signed [31:0] rx_s3, ry_s3;
	logic               ov_s3;
	logic signed [64:0] mx_s4, my_s4;
	logic               ov_s4;
	porm_pkg::result_t  res_s5;

	logic signed [65:0] sum_x, sum_y;
	logic signed [65:0] rot_x, rot_y;
	logic signed [65:0] rsh_x, rsh_y;
	logic signed [31:0] rx_sat;
	logic signed [65:0] sc_x, sc_y;

	assign advance  = !(v_s5 && out_stall);
	assign in_stall = !advance || trig.busy;
	assign take     = in_valid && !in_stall;

	always_comb begin
		sum_x  = 66'(in_data.point_x) + 66'(offset_x);
		sum_y  = 66'(in_data.point_y) + 66'(offset_y);
		rot_x  = (66'(cx_s2) - 66'(sy_s2) + porm_pkg::ROUND_Q30) >>> 30;
		rot_y  = (66'(sx_s2) + 66'(cy_s2) + porm_pkg::ROUND_Q30) >>> 30;
		rx_sat = porm_pkg::sat_val(rot_x);
		rsh_x  = 66'(mx_s4) + porm_pkg::ROUND_Q16;
		rsh_y  = 66'(my_s4) + porm_pkg::ROUND_Q16;
		sc_x   = rsh_x >>> 16;
		sc_y   = rsh_y >>> 16;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (advance) begin
			v_s1 <= take;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			x_s1  <= porm_pkg::sat_val(sum_x);
			y_s1  <= porm_pkg::sat_val(sum_y);
			ov_s1 <= porm_pkg::sat_hit(sum_x) || porm_pkg::sat_hit(sum_y);

			cx_s2 <= trig.cos_v * x_s1;
			sy_s2 <= trig.sin_v * y_s1;
			sx_s2 <= trig.sin_v * x_s1;
			cy_s2 <= trig.cos_v * y_s1;
			ov_s2 <= ov_s1;

			ry_s3 <= porm_pkg::sat_val(rot_y);
			if (mirror) begin
				rx_s3 <= (rx_sat == 32'sh80000000) ? 32'sh7fffffff : -rx_sat;
			end else begin
				rx_s3 <= rx_sat;
			end
			ov_s3 <= ov_s2 || porm_pkg::sat_hit(rot_x) || porm_pkg::sat_hit(rot_y)
				|| (mirror && (rx_sat == 32'sh80000000));

			mx_s4 <= 65'(rx_s3) * $signed({1'b0, scale});
			my_s4 <= 65'(ry_s3) * $signed({1'b0, scale});
			ov_s4 <= ov_s3;

			res_s5.result_x <= porm_pkg::sat_val(sc_x);
			res_s5.result_y <= porm_pkg::sat_val(sc_y);
			res_s5.overflow <= ov_s4 || porm_pkg::sat_hit(sc_x) || porm_pkg::sat_hit(sc_y);
		end
	end

	assign out_valid = v_s5;
	assign out_data  = res_s5;

endmodule

`default_nettype wire

FILE: sv/point_offset_rotate_mirror_scale_top.sv
// ----------------------------------------------------------------------------
// point_offset_rotate_mirror_scale_top
// 2D point transform: offset, rotate, optional x mirror, scale.
// ----------------------------------------------------------------------------
// Takes one point per clock unless in_stall is high, and delivers each result
// through the five-stage point pipeline. Cosine and sine come from one
// shared iterative CORDIC that reruns after each turn_angle write; in_stall
// stays high while it runs, and also while a held result is back-pressured.
`default_nettype none

module point_offset_rotate_mirror_scale_top #(
	parameter int ROTATE_STEPS = porm_pkg::ROTATE_STEPS_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_stall,
	input  wire porm_pkg::point_t in_data,
	output logic               out_valid,
	input  wire logic          out_stall,
	output porm_pkg::result_t  out_data,
	input  wire logic          cfg_we,
	input  wire logic [2:0]    cfg_index,
	input  wire logic [31:0]   cfg_data
);

	logic signed [31:0] offset_x_q;
	logic signed [31:0] offset_y_q;
	logic [15:0]        angle_q;
	logic               mirror_q;
	logic [31:0]        scale_q;
	logic               angle_wr;
	porm_pkg::trig_t    trig;

	assign angle_wr = cfg_we && (cfg_index == porm_pkg::CFG_TURN_ANGLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_x_q <= '0;
			offset_y_q <= '0;
			angle_q    <= '0;
			mirror_q   <= 1'b0;
			scale_q    <= porm_pkg::SCALE_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				porm_pkg::CFG_OFFSET_X:      offset_x_q <= cfg_data;
				porm_pkg::CFG_OFFSET_Y:      offset_y_q <= cfg_data;
				porm_pkg::CFG_TURN_ANGLE:    angle_q    <= cfg_data[15:0];
				porm_pkg::CFG_MIRROR_ENABLE: mirror_q   <= cfg_data[0];
				porm_pkg::CFG_SCALE_FACTOR:  scale_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	porm_sincos #(
		.ROTATE_STEPS(ROTATE_STEPS)
	) u_sincos (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (angle_wr),
		.angle  (angle_q),
		.trig   (trig)
	);

	porm_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.offset_x  (offset_x_q),
		.offset_y  (offset_y_q),
		.mirror    (mirror_q),
		.scale     (scale_q),
		.trig      (trig)
	);

endmodule

`default_nettype wire

FILE: sv/porm_checker.sv
// ----------------------------------------------------------------------------
// porm_checker
// Port-level checks on the point transform, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module porm_checker (
	input wire logic          clk,
	input wire logic          arst_n,
	input wire logic          in_valid,
	input wire logic          in_stall,
	input wire porm_pkg::point_t  in_data,
	input wire logic          out_valid,
	input wire logic          out_stall,
	input wire porm_pkg::result_t out_data,
	input wire logic          cfg_we,
	input wire logic [2:0]    cfg_index,
	input wire logic [31:0]   cfg_data
);

	`ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, $stable(out_data))
	`ASSERT_NOW(a_backpressure, clk, arst_n, out_valid && out_stall, in_stall)
	`ASSERT_NEXT(a_angle_stall, clk, arst_n, cfg_we && (cfg_index == porm_pkg::CFG_TURN_ANGLE), in_stall)

endmodule

bind point_offset_rotate_mirror_scale_top porm_checker u_porm_checker (.*);

`default_nettype wire

FILE: bench/point_offset_rotate_mirror_scale_top_test.sv
// ----------------------------------------------------------------------------
// point_offset_rotate_mirror_scale_top_test
// Checks the point transform against a bit-exact predictor of offset,
// CORDIC rotation, mirror and scale, under varied idling and back-pressure.
// ----------------------------------------------------------------------------
`default_nettype none

module point_offset_rotate_mirror_scale_top_test;

	localparam int STEPS = 16;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	porm_pkg::point_t in_data;
	logic out_valid;
	logic out_stall;
	porm_pkg::result_t out_data;
	logic cfg_we;
	logic [2:0] cfg_index;
	logic [31:0] cfg_data;

	point_offset_rotate_mirror_scale_top #(.ROTATE_STEPS(STEPS)) dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	longint off_x, off_y;
	logic [15:0] angle;
	logic mirror;
	longint scale;

	porm_pkg::result_t pending_results[$];
	int errors;
	int send_idle_pct;
	int recv_stall_pct;
	int hold_off_cycles;

	const longint ATAN_TBL[24] = '{
		536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
		10679838, 5340245, 2670163, 1335087, 667544, 333772,
		166886, 83443, 41722, 20861, 10430, 5215,
		2608, 1304, 652, 326, 163, 81};

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic longint shr_floor(longint v, int s);
		return v >>> s;
	endfunction

	function automatic longint clip32(longint v, inout logic ovf);
		if (v > 64'sd2147483647) begin
			ovf = 1'b1;
			return 64'sd2147483647;
		end
		if (v < -64'sd2147483648) begin
			ovf = 1'b1;
			return -64'sd2147483648;
		end
		return v;
	endfunction

	function automatic longint clip_unit(longint v);
		if (v > 64'sd1073741824) return 64'sd1073741824;
		if (v < -64'sd1073741824) return -64'sd1073741824;
		return v;
	endfunction

	function automatic porm_pkg::result_t transform_point(porm_pkg::point_t p);
		porm_pkg::result_t r;
		logic ovf;
		longint x, y, c, s, t, cx, cy, z, dx, dy, rx, ry, res, q;
		ovf = 1'b0;
		x = clip32(longint'(p.point_x) + off_x, ovf);
		y = clip32(longint'(p.point_y) + off_y, ovf);
		q = ((longint'(angle) + 8192) >> 14) & 3;
		res = longint'(angle) - q * 16384;
		if (res > 32767) res -= 65536;
		if (res == 0) begin
			c = 64'sd1073741824;
			s = 0;
		end else begin
			cx = 652032874;
			cy = 0;
			z = res * 65536;
			for (int i = 0; i < STEPS && i < 24; i++) begin
				dx = shr_floor(cy, i);
				dy = shr_floor(cx, i);
				if (z >= 0) begin
					cx -= dx; cy += dy; z -= ATAN_TBL[i];
				end else begin
					cx += dx; cy -= dy; z += ATAN_TBL[i];
				end
			end
			c = cx;
			s = cy;
		end
		if (q == 1) begin
			t = c; c = -s; s = t;
		end else if (q == 2) begin
			c = -c; s = -s;
		end else if (q == 3) begin
			t = c; c = s; s = -t;
		end
		c = clip_unit(c);
		s = clip_unit(s);
		rx = clip32(shr_floor(c * x - s * y + 536870912, 30), ovf);
		ry = clip32(shr_floor(s * x + c * y + 536870912, 30), ovf);
		if (mirror) rx = clip32(-rx, ovf);
		rx = clip32(shr_floor(rx * scale + 32768, 16), ovf);
		ry = clip32(shr_floor(ry * scale + 32768, 16), ovf);
		r.result_x = rx[31:0];
		r.result_y = ry[31:0];
		r.overflow = ovf;
		return r;
	endfunction

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [31:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			porm_pkg::CFG_OFFSET_X:      off_x = longint'(signed'(val));
			porm_pkg::CFG_OFFSET_Y:      off_y = longint'(signed'(val));
			porm_pkg::CFG_TURN_ANGLE:    angle = val[15:0];
			porm_pkg::CFG_MIRROR_ENABLE: mirror = val[0];
			porm_pkg::CFG_SCALE_FACTOR:  scale = longint'(val);
			default: ;
		endcase
	endtask

	task automatic apply_setting(logic [31:0] ox, logic [31:0] oy, logic [15:0] ang,
			logic mir, logic [31:0] sc);
		wait_drained();
		write_reg(porm_pkg::CFG_OFFSET_X, ox);
		write_reg(porm_pkg::CFG_OFFSET_Y, oy);
		write_reg(porm_pkg::CFG_TURN_ANGLE, {16'd0, ang});
		write_reg(porm_pkg::CFG_MIRROR_ENABLE, {31'd0, mir});
		write_reg(porm_pkg::CFG_SCALE_FACTOR, sc);
	endtask

	// hold valid through stalls; predict at acceptance
	task automatic send_point(porm_pkg::point_t p);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= p;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		pending_results.push_back(transform_point(p));
	endtask

	function automatic logic [31:0] rand_coord();
		case ($urandom_range(5))
			0: return 32'h7fffffff - $urandom_range(3);
			1: return 32'h80000000 + $urandom_range(3);
			2: return $urandom_range(255) << 16;
			3: return -($urandom_range(255) << 16);
			default: return $urandom();
		endcase
	endfunction

	task automatic send_random(int n);
		porm_pkg::point_t p;
		for (int i = 0; i < n; i++) begin
			p.point_x = rand_coord();
			p.point_y = rand_coord();
			send_point(p);
		end
	endtask

	task automatic test_identity();
		porm_pkg::point_t p;
		logic [31:0] edges[6] = '{32'h0, 32'h1, 32'hffffffff, 32'h7fffffff,
			32'h80000000, 32'h00010000};
		foreach (edges[i]) begin
			p.point_x = edges[i];
			p.point_y = edges[5 - i];
			send_point(p);
		end
	endtask

	task automatic test_special_cases();
		porm_pkg::point_t p;
		apply_setting(32'h0, 32'h0, 16'd0, 1'b1, porm_pkg::SCALE_RESET);
		p.point_x = 32'h80000000;
		p.point_y = 32'h7fffffff;
		send_point(p);
		apply_setting(32'h7fffffff, 32'h80000000, 16'd16384, 1'b0, 32'h0);
		p.point_x = 32'h00000100;
		p.point_y = 32'hffffff00;
		send_point(p);
		apply_setting(32'h0, 32'h0, 16'd32768, 1'b0, 32'hffffffff);
		p.point_x = 32'h00010000;
		p.point_y = 32'hfffe0000;
		send_point(p);
		send_point(p);
		wait_drained();
		write_reg(3'd7, 32'hffffffff);
		write_reg(3'd5, 32'h0);
		send_point(p);
	endtask

	task automatic test_angles();
		logic [15:0] angs[7] = '{16'd16384, 16'd49152, 16'd8192, 16'd57344,
			16'd65535, 16'd1, 16'd24576};
		foreach (angs[i]) begin
			apply_setting($urandom(), $urandom(), angs[i], i[0], 32'h00010000 << (i % 3));
			send_random(2);
		end
	endtask

	task automatic test_random_phases();
		int idle_tbl[4] = '{0, 50, 0, 28};
		int stall_tbl[4] = '{0, 0, 50, 28};
		for (int ph = 0; ph < 12; ph++) begin
			send_idle_pct = idle_tbl[ph % 4];
			recv_stall_pct = stall_tbl[ph % 4];
			apply_setting($urandom_range(3) == 0 ? $urandom() : $urandom_range(65535) << 8,
				$urandom_range(3) == 0 ? $urandom() : $urandom_range(65535) << 8,
				$urandom(), $urandom_range(1),
				$urandom_range(3) == 0 ? $urandom() : $urandom_range(196608));
			send_random(58);
		end
		send_idle_pct = 0;
		recv_stall_pct = 0;
	endtask

	task automatic test_back_pressure();
		hold_off_cycles = 60;
		send_random(30);
		wait_drained();
		send_random(10);
	endtask

	always @(posedge clk) begin
		if (hold_off_cycles > 0) begin
			hold_off_cycles <= hold_off_cycles - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		porm_pkg::result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				$display("%0t unexpected result: actual %h", $time, out_data);
				errors++;
			end else begin
				want = pending_results.pop_front();
				if (out_data !== want) begin
					$display("%0t mismatch: expected x=%h y=%h ovf=%b actual x=%h y=%h ovf=%b",
						$time, want.result_x, want.result_y, want.overflow,
						out_data.result_x, out_data.result_y, out_data.overflow);
					errors++;
				end
			end
		end
	end

	initial begin
		#20000000;
		$display("[point_offset_rotate_mirror_scale_top] ERROR");
		$finish;
	end

	initial begin
		errors = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_off_cycles = 0;
		off_x = 0;
		off_y = 0;
		angle = 0;
		mirror = 0;
		scale = 65536;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		out_stall = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_identity();
		test_special_cases();
		test_angles();
		test_random_phases();
		test_back_pressure();
		wait_drained();
		if (errors == 0) begin
			$display("[point_offset_rotate_mirror_scale_top] OK");
		end else begin
			$display("[point_offset_rotate_mirror_scale_top] ERROR");
		end
		$finish;
	end

endmodule

`default_nettype wire
